>>> sv/assert_macros.svh
// Assertion helpers for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/rlmf_pkg.sv
package rlmf_pkg;

   localparam int VALUE_BITS     = 16;
   localparam int POS_OUT_BITS   = 7;
   localparam int CFG_BITS       = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int DEF_MAX_COLS   = 128;
   localparam int DEF_MAX_ROWS   = 128;
   localparam int QUEUE_DEPTH    = 4;
   localparam int N_CAND         = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd1;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [POS_OUT_BITS-1:0]      pos_type;

   typedef struct packed {
      pos_type   row;
      pos_type   col;
      value_type value;
   } cand_type;

   // One queue entry: up to three decided cells, in raster order.
   typedef struct packed {
      logic [N_CAND-1:0]     hit;
      cand_type [N_CAND-1:0] cand;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } q_head_type;

endpackage

>>> sv/raster_local_minimum_finder.sv
// A result passes the queue and the output register before it shows on the rsp_ ports.
// Throughput: one item per cycle unless req_full; results leave one per cycle while
// rsp_pop is high; a 4-entry queue absorbs the two or three results of a last-row item.
// Line buffers are two single-port-read RAMs read one item ahead of the stream.
// Reset (synchronous) sets a 1x1 frame, clears position, queue and output;
// line buffer contents are not cleared.
module raster_local_minimum_finder #(
   parameter int MAX_COLS = rlmf_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = rlmf_pkg::DEF_MAX_ROWS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  rlmf_pkg::value_type                 req_cell_value,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [rlmf_pkg::POS_OUT_BITS-1:0]   rsp_min_row,
   output logic [rlmf_pkg::POS_OUT_BITS-1:0]   rsp_min_col,
   output rlmf_pkg::value_type                 rsp_min_value,
   output logic                                rsp_run_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rlmf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rlmf_pkg::CFG_BITS-1:0]       csr_data
);
   import rlmf_pkg::*;

   logic       q_push, q_full, q_pop;
   entry_type  q_entry;
   q_head_type q_head;

   assign req_full = q_full;

   rlmf_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_push),
      .in_value  (req_cell_value),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   rlmf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .entry_in (q_entry),
      .full     (q_full),
      .head     (q_head),
      .pop      (q_pop)
   );

   rlmf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .min_row   (rsp_min_row),
      .min_col   (rsp_min_col),
      .min_value (rsp_min_value),
      .run_last  (rsp_run_last)
   );
endmodule

>>> sv/rlmf_ram.sv
module rlmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

>>> sv/rlmf_front.sv
module rlmf_front #(
   parameter int MAX_COLS = rlmf_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = rlmf_pkg::DEF_MAX_ROWS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  rlmf_pkg::value_type                  in_value,
   input  logic                                 q_full,
   output logic                                 q_push,
   output rlmf_pkg::entry_type                  q_entry,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rlmf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rlmf_pkg::CFG_BITS-1:0]        csr_data
);
   import rlmf_pkg::*;

   localparam int COL_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int WSZ_BITS = $clog2(MAX_COLS + 1);
   localparam int HSZ_BITS = $clog2(MAX_ROWS + 1);

   logic [HSZ_BITS-1:0] h_eff_ff, h_eff_in, h_new;
   logic [WSZ_BITS-1:0] w_eff_ff, w_eff_in, w_new;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic                flag_ff, flag_in;

   // Window over the line above plus the last two items of this row.
   value_type first_ff, nw1_ff, nw2_ff, prev1_ff, prev2_ff, wdata_ff;
   logic      hit_a_ff, hit_a_in, hit_b_ff, hit_b_in;

   logic                accept, cfg_hit, last_col, last_row;
   logic [COL_BITS-1:0] old_addr, nw_addr, raddr_a, raddr_b;
   logic                we_a, we_b;
   value_type           q_a, q_b, qa_eff, qb_eff, old_q, nw_q, nw_c;
   logic                ok0, ok1, ok2;

   assign csr_ready = 1'b1;
   assign accept    = in_valid && !q_full;
   assign cfg_hit   = csr_valid &&
                      (csr_index == CSR_FRAME_HEIGHT || csr_index == CSR_FRAME_WIDTH);

   // Zero acts as one, oversize saturates.
   assign h_new = (csr_data == '0) ? HSZ_BITS'(1) :
                  (32'(csr_data) > MAX_ROWS) ? HSZ_BITS'(MAX_ROWS) : HSZ_BITS'(csr_data);
   assign w_new = (csr_data == '0) ? WSZ_BITS'(1) :
                  (32'(csr_data) > MAX_COLS) ? WSZ_BITS'(MAX_COLS) : WSZ_BITS'(csr_data);

   assign last_col = (32'(col_ff) + 1 >= 32'(w_eff_ff));
   assign last_row = (32'(row_ff) + 1 >= 32'(h_eff_ff));

   always_comb begin
      h_eff_in = h_eff_ff;
      w_eff_in = w_eff_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      flag_in  = flag_ff;
      if (cfg_hit) begin
         if (csr_index == CSR_FRAME_HEIGHT) begin
            h_eff_in = h_new;
         end else begin
            w_eff_in = w_new;
         end
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in  = '0;
            flag_in = !flag_ff;
            row_in  = last_row ? '0 : ROW_BITS'(row_ff + 1'b1);
         end else begin
            col_in = COL_BITS'(col_ff + 1'b1);
         end
      end
   end

   // Reads are issued for the position of the next item.
   assign old_addr = col_in;
   assign nw_addr  = COL_BITS'(col_in + 1'b1);
   assign raddr_a  = flag_in ? nw_addr : old_addr;
   assign raddr_b  = flag_in ? old_addr : nw_addr;
   assign we_a     = accept && !flag_ff;
   assign we_b     = accept && flag_ff;
   assign hit_a_in = we_a && (col_ff == raddr_a);
   assign hit_b_in = we_b && (col_ff == raddr_b);

   rlmf_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_COLS)) u_older_row_store (
      .clock (clock),
      .we    (we_a),
      .waddr (col_ff),
      .wdata (in_value),
      .raddr (raddr_a),
      .rdata (q_a)
   );

   rlmf_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_COLS)) u_newer_row_store (
      .clock (clock),
      .we    (we_b),
      .waddr (col_ff),
      .wdata (in_value),
      .raddr (raddr_b),
      .rdata (q_b)
   );

   // Write-to-read forwarding for the row turn on a two-column frame.
   assign qa_eff = hit_a_ff ? wdata_ff : q_a;
   assign qb_eff = hit_b_ff ? wdata_ff : q_b;
   assign old_q  = flag_ff ? qb_eff : qa_eff;
   assign nw_q   = flag_ff ? qa_eff : qb_eff;
   assign nw_c   = (col_ff == '0) ? first_ff : nw1_ff;

   // Cell above the current one, decided by its lower neighbor.
   assign ok0 = (row_ff != '0) &&
                (!(row_ff > 1) || nw_c < old_q) &&
                (nw_c < in_value) &&
                (col_ff == '0 || nw_c < nw2_ff) &&
                (last_col || nw_c < nw_q);
   // Last row: left cell, decided by its right neighbor.
   assign ok1 = last_row && (col_ff != '0) &&
                (row_ff == '0 || prev1_ff < nw2_ff) &&
                (!(col_ff > 1) || prev1_ff < prev2_ff) &&
                (prev1_ff < in_value);
   // Final cell of the frame.
   assign ok2 = last_row && last_col &&
                (row_ff == '0 || in_value < nw_c) &&
                (col_ff == '0 || in_value < prev1_ff);

   always_comb begin
      q_entry.hit           = {ok2, ok1, ok0};
      q_entry.cand[0].row   = POS_OUT_BITS'(row_ff - 1'b1);
      q_entry.cand[0].col   = POS_OUT_BITS'(col_ff);
      q_entry.cand[0].value = nw_c;
      q_entry.cand[1].row   = POS_OUT_BITS'(row_ff);
      q_entry.cand[1].col   = POS_OUT_BITS'(col_ff - 1'b1);
      q_entry.cand[1].value = prev1_ff;
      q_entry.cand[2].row   = POS_OUT_BITS'(row_ff);
      q_entry.cand[2].col   = POS_OUT_BITS'(col_ff);
      q_entry.cand[2].value = in_value;
   end

   assign q_push = accept && (ok0 || ok1 || ok2);

   always_ff @(posedge clock) begin
      if (reset) begin
         h_eff_ff <= HSZ_BITS'(1);
         w_eff_ff <= WSZ_BITS'(1);
         row_ff   <= '0;
         col_ff   <= '0;
         flag_ff  <= 1'b0;
         hit_a_ff <= 1'b0;
         hit_b_ff <= 1'b0;
      end else begin
         h_eff_ff <= h_eff_in;
         w_eff_ff <= w_eff_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         flag_ff  <= flag_in;
         hit_a_ff <= hit_a_in;
         hit_b_ff <= hit_b_in;
      end
   end

   always_ff @(posedge clock) begin
      wdata_ff <= in_value;
      if (accept) begin
         nw1_ff   <= nw_q;
         nw2_ff   <= nw_c;
         prev1_ff <= in_value;
         prev2_ff <= prev1_ff;
         if (col_ff == '0) begin
            first_ff <= in_value;
         end
      end
   end
endmodule

>>> sv/rlmf_queue.sv
module rlmf_queue #(
   parameter int DEPTH = rlmf_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rlmf_pkg::entry_type  entry_in,
   output logic                 full,
   output rlmf_pkg::q_head_type head,
   input  logic                 pop
);
   import rlmf_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   entry_type           mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == CNT_BITS'(DEPTH));
   assign do_push    = push && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : PTR_BITS'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : PTR_BITS'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_BITS'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_BITS'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end
endmodule

>>> sv/rlmf_back.sv
module rlmf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  rlmf_pkg::q_head_type head,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rlmf_pkg::pos_type    min_row,
   output rlmf_pkg::pos_type    min_col,
   output rlmf_pkg::value_type  min_value,
   output logic                 run_last
);
   import rlmf_pkg::*;

   logic [N_CAND-1:0] done_ff, done_in, remaining, pick;
   logic              out_valid_ff, out_valid_in;
   cand_type          out_ff, sel;
   logic              last_ff, last, load;

   assign remaining = head.entry.hit & ~done_ff;
   assign pick      = remaining & (~remaining + 1'b1);
   assign last      = ((remaining & ~pick) == '0);
   assign load      = head.valid && (!out_valid_ff || rsp_pop);
   assign q_pop     = load && last;

   always_comb begin
      sel = head.entry.cand[0];
      for (int k = N_CAND - 1; k >= 0; k--) begin
         if (remaining[k]) begin
            sel = head.entry.cand[k];
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      done_in      = done_ff;
      if (load) begin
         out_valid_in = 1'b1;
         done_in      = last ? '0 : (done_ff | pick);
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff  <= sel;
         last_ff <= last;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign min_row   = out_ff.row;
   assign min_col   = out_ff.col;
   assign min_value = out_ff.value;
   assign run_last  = last_ff;
endmodule

>>> sv/rlmf_checker.sv
`include "assert_macros.svh"

module rlmf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_push,
   input logic                                req_full,
   input rlmf_pkg::value_type                 req_cell_value,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input logic [rlmf_pkg::POS_OUT_BITS-1:0]   rsp_min_row,
   input logic [rlmf_pkg::POS_OUT_BITS-1:0]   rsp_min_col,
   input rlmf_pkg::value_type                 rsp_min_value,
   input logic                                rsp_run_last,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [rlmf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [rlmf_pkg::CFG_BITS-1:0]       csr_data
);
   `CHK_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty,
                      "result pending right after reset")

   `CHK_ASSERT_ALWAYS(a_reset_not_full, clock, reset |=> !req_full,
                      "input blocked right after reset")

   // The output stage loads when the queue holds an item and the output is empty or popped.
   `CHK_ASSERT(a_full_has_result, clock, reset, req_full |-> !rsp_empty,
               "queue full while no result is offered")

   `CHK_ASSERT(a_stall_hold, clock, reset,
               (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_min_row) &&
                  $stable(rsp_min_col) && $stable(rsp_min_value) && $stable(rsp_run_last)),
               "stalled result changed")
endmodule

bind raster_local_minimum_finder rlmf_checker u_rlmf_checker (.*);
